FILE: sv/mh_pkg.sv
`default_nettype none

package mh_pkg;

    localparam int RAW_W      = 16;
    localparam int OFF_W      = 12;
    localparam int SCALE_W    = 16;
    localparam int DIFF_W     = 17;
    localparam int PROD_W     = 33;
    localparam int FIELD_W    = 25;
    localparam int HEAD_W     = 15;
    localparam int FIELD_FRAC = 8;   // product bits dropped when going from Q.12 to Q.4
    localparam int PRE_SHIFT  = 24;  // extra fraction bits on the CORDIC vector
    localparam int CW         = 52;  // CORDIC x/y width: field + pre-shift + growth
    localparam int ZW         = 33;  // angle accumulator, 2^-22 degree units
    localparam int ANG_FRAC   = 22;
    localparam int HEAD_SHIFT = 16;  // 2^-22 degree down to 1/64 degree
    localparam int TAB_LEN    = 24;

    localparam logic [1:0] REG_X_BIAS = 2'd0;
    localparam logic [1:0] REG_Y_BIAS = 2'd1;
    localparam logic [1:0] REG_SCALE  = 2'd2;

    localparam logic signed [OFF_W-1:0]   X_BIAS_RST = 12'sd11;
    localparam logic signed [OFF_W-1:0]   Y_BIAS_RST = -12'sd107;
    localparam logic        [SCALE_W-1:0] SCALE_RST  = 16'd3768;

    localparam logic signed [ZW-1:0] Z_HALF_TURN = ZW'(180 * (2 ** ANG_FRAC));
    localparam logic signed [ZW-1:0] Z_FULL_TURN = ZW'(360 * (2 ** ANG_FRAC));
    localparam logic signed [ZW-1:0] Z_ROUND     = ZW'(2 ** (HEAD_SHIFT - 1));
    localparam logic [HEAD_W:0]      FULL_TURN_OUT = 16'd23040;

    // atan(2^-i), 2^-22 degree units
    localparam logic signed [ZW-1:0] ATAN_TAB [TAB_LEN] = '{
        33'sd188743680, 33'sd111421900, 33'sd58872272, 33'sd29884485,
        33'sd15000234,  33'sd7507429,   33'sd3754631,  33'sd1877430,
        33'sd938729,    33'sd469366,    33'sd234683,   33'sd117342,
        33'sd58671,     33'sd29335,     33'sd14668,    33'sd7334,
        33'sd3667,      33'sd1833,      33'sd917,      33'sd458,
        33'sd229,       33'sd115,       33'sd57,       33'sd29
    };

    typedef struct packed {
        logic signed [FIELD_W-1:0] x_field;
        logic signed [FIELD_W-1:0] y_field;
    } fields_t;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [ZW-1:0] z;
        logic                 zero;
        fields_t              f;
    } cordic_t;

endpackage

`default_nettype wire

FILE: sv/mh_front.sv
`default_nettype none

// Offset removal, gain multiply, Q.4 rounding and CORDIC set-up: four stages.
module mh_front (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 en,
    input  wire logic                                 valid_in,
    input  wire logic signed [mh_pkg::RAW_W-1:0]      x_raw,
    input  wire logic signed [mh_pkg::RAW_W-1:0]      y_raw,
    input  wire logic signed [mh_pkg::OFF_W-1:0]      x_bias,
    input  wire logic signed [mh_pkg::OFF_W-1:0]      y_bias,
    input  wire logic        [mh_pkg::SCALE_W-1:0]    scale,
    output logic                                      valid_out,
    output mh_pkg::cordic_t                           data_out
);

    localparam int EXT_W = mh_pkg::CW - mh_pkg::FIELD_W - mh_pkg::PRE_SHIFT;

    logic [3:0] valid_reg;

    logic signed [mh_pkg::DIFF_W-1:0] dx_reg, dy_reg, dx_next, dy_next;
    logic signed [mh_pkg::PROD_W-1:0] px_reg, py_reg, px_next, py_next;
    logic signed [2*mh_pkg::DIFF_W-1:0] px_full, py_full;
    logic signed [mh_pkg::DIFF_W-1:0] scale_s;
    logic signed [mh_pkg::PROD_W-1:0] rx, ry;
    mh_pkg::fields_t f_reg, f_next;
    mh_pkg::cordic_t c_reg, c_next;
    logic signed [mh_pkg::CW-1:0] xs, ys;
    logic neg;

    // stage 1: remove hard-iron offset
    assign dx_next = {x_raw[mh_pkg::RAW_W-1], x_raw}
                   - {{(mh_pkg::DIFF_W-mh_pkg::OFF_W){x_bias[mh_pkg::OFF_W-1]}}, x_bias};
    assign dy_next = {y_raw[mh_pkg::RAW_W-1], y_raw}
                   - {{(mh_pkg::DIFF_W-mh_pkg::OFF_W){y_bias[mh_pkg::OFF_W-1]}}, y_bias};

    // stage 2: gain, Q.12 product
    assign scale_s = $signed({1'b0, scale});
    assign px_full = dx_reg * scale_s;
    assign py_full = dy_reg * scale_s;
    assign px_next = px_full[mh_pkg::PROD_W-1:0];
    assign py_next = py_full[mh_pkg::PROD_W-1:0];

    // stage 3: round half away from zero; negatives add 127 then floor
    assign rx = px_reg + (px_reg[mh_pkg::PROD_W-1] ? 33'sd127 : 33'sd128);
    assign ry = py_reg + (py_reg[mh_pkg::PROD_W-1] ? 33'sd127 : 33'sd128);
    assign f_next.x_field = rx[mh_pkg::FIELD_FRAC +: mh_pkg::FIELD_W];
    assign f_next.y_field = ry[mh_pkg::FIELD_FRAC +: mh_pkg::FIELD_W];

    // stage 4: fold left half-plane onto the right, start angle at 180
    assign neg = f_reg.x_field[mh_pkg::FIELD_W-1];
    assign xs  = {{EXT_W{f_reg.x_field[mh_pkg::FIELD_W-1]}}, f_reg.x_field,
                  {mh_pkg::PRE_SHIFT{1'b0}}};
    assign ys  = {{EXT_W{f_reg.y_field[mh_pkg::FIELD_W-1]}}, f_reg.y_field,
                  {mh_pkg::PRE_SHIFT{1'b0}}};

    always_comb
    begin
        c_next.x    = neg ? -xs : xs;
        c_next.y    = neg ? -ys : ys;
        c_next.z    = neg ? mh_pkg::Z_HALF_TURN : '0;
        c_next.zero = (f_reg.x_field == '0) && (f_reg.y_field == '0);
        c_next.f    = f_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[2:0], valid_in};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dx_reg <= dx_next;
            dy_reg <= dy_next;
            px_reg <= px_next;
            py_reg <= py_next;
            f_reg  <= f_next;
            c_reg  <= c_next;
        end
    end

    assign valid_out = valid_reg[3];
    assign data_out  = c_reg;

endmodule

`default_nettype wire

FILE: sv/mh_cordic_stage.sv
`default_nettype none

// One vectoring CORDIC iteration, registered.
module mh_cordic_stage #(
    parameter int STEP = 0
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            en,
    input  wire logic            valid_in,
    input  wire mh_pkg::cordic_t data_in,
    output logic                 valid_out,
    output mh_pkg::cordic_t      data_out
);

    logic            valid_reg;
    mh_pkg::cordic_t c_reg, c_next;
    logic signed [mh_pkg::CW-1:0] xs, ys;
    logic rot_cw;

    assign xs     = data_in.x >>> STEP;
    assign ys     = data_in.y >>> STEP;
    assign rot_cw = !data_in.y[mh_pkg::CW-1] && (data_in.y != '0);

    always_comb
    begin
        c_next = data_in;
        if (rot_cw)
        begin
            c_next.x = data_in.x + ys;
            c_next.y = data_in.y - xs;
            c_next.z = data_in.z + mh_pkg::ATAN_TAB[STEP];
        end
        else
        begin
            c_next.x = data_in.x - ys;
            c_next.y = data_in.y + xs;
            c_next.z = data_in.z - mh_pkg::ATAN_TAB[STEP];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_reg <= c_next;
        end
    end

    assign valid_out = valid_reg;
    assign data_out  = c_reg;

endmodule

`default_nettype wire

FILE: sv/mh_post.sv
`default_nettype none

// Angle wrap into 0..360, round to 1/64 degree, full-turn wrap; a zero
// vector gives heading 0. Second stage is the output register.
module mh_post (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          en,
    input  wire logic                          valid_in,
    input  wire mh_pkg::cordic_t               data_in,
    output logic                               valid_out,
    output logic        [mh_pkg::HEAD_W-1:0]   heading,
    output mh_pkg::fields_t                    fields
);

    logic [1:0] valid_reg;

    logic signed [mh_pkg::ZW-1:0] z_reg, z_next, z_sum;
    logic                         zero_a_reg;
    mh_pkg::fields_t              f_a_reg, f_b_reg;
    logic [mh_pkg::HEAD_W:0]      h_round;
    logic [mh_pkg::HEAD_W:0]      h_wrap;
    logic [mh_pkg::HEAD_W-1:0]    head_reg, head_next;

    assign z_next = data_in.z[mh_pkg::ZW-1] ? data_in.z + mh_pkg::Z_FULL_TURN : data_in.z;

    assign z_sum   = z_reg + mh_pkg::Z_ROUND;
    assign h_round = z_sum[mh_pkg::HEAD_SHIFT +: (mh_pkg::HEAD_W+1)];
    assign h_wrap  = (h_round >= mh_pkg::FULL_TURN_OUT) ? h_round - mh_pkg::FULL_TURN_OUT
                                                        : h_round;
    assign head_next = zero_a_reg ? '0 : h_wrap[mh_pkg::HEAD_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[0], valid_in};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            z_reg      <= z_next;
            zero_a_reg <= data_in.zero;
            f_a_reg    <= data_in.f;
            head_reg   <= head_next;
            f_b_reg    <= f_a_reg;
        end
    end

    assign valid_out = valid_reg[1];
    assign heading   = head_reg;
    assign fields    = f_b_reg;

endmodule

`default_nettype wire

FILE: sv/magnetometer_heading_top.sv
// Magnetometer heading pipeline.
// Input stream (s_axis_*): one beat per sample, raw signed x and y counts.
// Output stream (m_axis_*): one beat per sample, heading in 1/64 degree
// (0..23039) and the offset-corrected, scaled x/y fields in signed Q.4.
// Config port: cfg_we/cfg_index/cfg_data write the x bias (0), y bias (1)
// and scale (2, unsigned Q4.12); other indexes are ignored. Write only
// while the pipeline is empty.
// Pipeline: 4 front stages, one per CORDIC iteration, 2 output stages.
// Throughput: one beat per cycle while not stalled; the whole pipeline
// advances together, one CORDIC iteration per stage.
// Stall: when m_axis_tready is low with a beat waiting at the output, every
// stage holds and s_axis_tready drops; nothing is lost or repeated.
// Reset: offsets and scale return to 11, -107 and 3768; all valid bits clear.
`default_nettype none

module magnetometer_heading_top #(
    parameter int CORDIC_STEPS = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // x_raw[15:0], y_raw[31:16]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [71:0]      m_axis_tdata,   // heading[14:0], x_field[39:15],
                                             // y_field[64:40], zero pad [71:65]
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    logic signed [mh_pkg::OFF_W-1:0] x_bias_reg, y_bias_reg;
    logic        [mh_pkg::SCALE_W-1:0] scale_reg;

    logic en;
    logic            valid_c [CORDIC_STEPS+1];
    mh_pkg::cordic_t data_c  [CORDIC_STEPS+1];
    logic [mh_pkg::HEAD_W-1:0] heading;
    mh_pkg::fields_t           fields;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_bias_reg <= mh_pkg::X_BIAS_RST;
            y_bias_reg <= mh_pkg::Y_BIAS_RST;
            scale_reg  <= mh_pkg::SCALE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                mh_pkg::REG_X_BIAS: x_bias_reg <= cfg_data[mh_pkg::OFF_W-1:0];
                mh_pkg::REG_Y_BIAS: y_bias_reg <= cfg_data[mh_pkg::OFF_W-1:0];
                mh_pkg::REG_SCALE:  scale_reg  <= cfg_data[mh_pkg::SCALE_W-1:0];
                default: ;
            endcase
        end
    end

    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    mh_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .valid_in  (s_axis_tvalid),
        .x_raw     (s_axis_tdata[15:0]),
        .y_raw     (s_axis_tdata[31:16]),
        .x_bias    (x_bias_reg),
        .y_bias    (y_bias_reg),
        .scale     (scale_reg),
        .valid_out (valid_c[0]),
        .data_out  (data_c[0])
    );

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_cordic
        mh_cordic_stage #(
            .STEP (i)
        ) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .valid_in  (valid_c[i]),
            .data_in   (data_c[i]),
            .valid_out (valid_c[i+1]),
            .data_out  (data_c[i+1])
        );
    end

    mh_post u_post (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .valid_in  (valid_c[CORDIC_STEPS]),
        .data_in   (data_c[CORDIC_STEPS]),
        .valid_out (m_axis_tvalid),
        .heading   (heading),
        .fields    (fields)
    );

    assign m_axis_tdata = {7'b0, fields.y_field, fields.x_field, heading};

endmodule

`default_nettype wire

FILE: sv/mh_checker.sv
`default_nettype none

module mh_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [71:0] m_axis_tdata
);

    // heading stays below a full turn
    a_heading_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[14:0] < 15'd23040))
        else $error("heading out of range");

    // zero field vector gives heading zero
    a_zero_vector: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[64:15] == 50'd0) |-> (m_axis_tdata[14:0] == 15'd0))
        else $error("zero vector with nonzero heading");

    // input side never stalls while the output side drains
    a_ready_follow: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tready |-> s_axis_tready)
        else $error("input stalled while output ready");

    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
        else $error("output beat dropped under stall");

    a_data_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
        else $error("output beat changed under stall");

endmodule

bind magnetometer_heading_top mh_checker u_mh_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

FILE: test/testbench.sv
`timescale 1ns / 100ps

module testbench;

    localparam int CORDIC_STEPS = 16;
    localparam int PIPE_LATENCY = CORDIC_STEPS + 6;
    localparam int ATAN_LEN     = 24;
    localparam int HOLD_CYCLES  = 300;
    localparam logic [1:0] REG_SPARE = 2'd3;  // unmapped index, write must be ignored

    // atan(2^-i) in 2^-22 degree
    localparam longint ATAN_STEP [ATAN_LEN] = '{
        188743680, 111421900, 58872272, 29884485, 15000234, 7507429,
        3754631, 1877430, 938729, 469366, 234683, 117342,
        58671, 29335, 14668, 7334, 3667, 1833,
        917, 458, 229, 115, 57, 29
    };
    localparam longint HALF_TURN_Z = longint'(180) <<< 22;
    localparam longint FULL_TURN_Z = longint'(360) <<< 22;
    localparam longint TURN_OUT    = 23040;

    typedef struct packed {
        logic        [mh_pkg::HEAD_W-1:0]  heading;
        logic signed [mh_pkg::FIELD_W-1:0] x_field;
        logic signed [mh_pkg::FIELD_W-1:0] y_field;
    } heading_res_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [71:0] m_axis_tdata;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;

    // local copy of the register file
    logic signed [mh_pkg::OFF_W-1:0] x_off_cfg = mh_pkg::X_BIAS_RST;
    logic signed [mh_pkg::OFF_W-1:0] y_off_cfg = mh_pkg::Y_BIAS_RST;
    logic [mh_pkg::SCALE_W-1:0]      scale_cfg = mh_pkg::SCALE_RST;

    logic [31:0]  sample_q [$];
    heading_res_t heading_q [$];
    int           mismatch_count = 0;
    int           send_idle_pct = 0;
    int           recv_stall_pct = 0;
    logic         stall_kick = 1'b0;
    int           hold_left = 0;

    magnetometer_heading_top #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #6 clk = ~clk;

    // (raw - offset) * scale, Q.12 rounded to Q.4 half away from zero
    function automatic longint correct_axis(longint raw, longint off);
        longint p;
        longint m;
        longint r;
        p = (raw - off) * longint'(scale_cfg);
        m = (p < 0) ? -p : p;
        r = (m + 128) >>> 8;
        return (p < 0) ? -r : r;
    endfunction

    function automatic logic [mh_pkg::HEAD_W-1:0] cordic_angle(longint xf, longint yf);
        longint x;
        longint y;
        longint z;
        longint xs;
        longint ys;
        longint h;
        if (xf == 0 && yf == 0)
            return '0;
        x = xf * (longint'(1) <<< 24);
        y = yf * (longint'(1) <<< 24);
        z = 0;
        // left half plane: mirror through origin, start from 180 degrees
        if (x < 0)
        begin
            x = -x;
            y = -y;
            z = HALF_TURN_Z;
        end
        for (int i = 0; i < CORDIC_STEPS && i < ATAN_LEN; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0)
            begin
                x = x + ys;
                y = y - xs;
                z = z + ATAN_STEP[i];
            end
            else
            begin
                x = x - ys;
                y = y + xs;
                z = z - ATAN_STEP[i];
            end
        end
        if (z < 0)
            z = z + FULL_TURN_Z;
        h = (z + (longint'(1) <<< 15)) >>> 16;
        if (h >= TURN_OUT)
            h = h - TURN_OUT;
        return h[mh_pkg::HEAD_W-1:0];
    endfunction

    function automatic heading_res_t predict_heading(logic signed [15:0] xr,
                                                     logic signed [15:0] yr);
        heading_res_t r;
        longint xf;
        longint yf;
        xf = correct_axis(longint'(xr), longint'(x_off_cfg));
        yf = correct_axis(longint'(yr), longint'(y_off_cfg));
        r.heading = cordic_angle(xf, yf);
        r.x_field = xf[mh_pkg::FIELD_W-1:0];
        r.y_field = yf[mh_pkg::FIELD_W-1:0];
        return r;
    endfunction

    // sample driver
    always @(posedge clk)
    begin
        if (!rst_n)
            s_axis_tvalid <= 1'b0;
        else if (!s_axis_tvalid || s_axis_tready)
        begin
            if (sample_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= sample_q.pop_front();
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // output backpressure, with a long hold-off on request
    always @(posedge clk)
    begin
        if (stall_kick)
            hold_left <= HOLD_CYCLES;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
        m_axis_tready <= (hold_left == 0 && !stall_kick) &&
                         ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin : scoreboard
        heading_res_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (heading_q.size() == 0)
            begin
                $error("output beat with nothing expected: %h", m_axis_tdata);
                mismatch_count++;
            end
            else
            begin
                want = heading_q.pop_front();
                if (m_axis_tdata[14:0] !== want.heading)
                begin
                    $error("heading: expected %0d, got %0d", want.heading,
                           m_axis_tdata[14:0]);
                    mismatch_count++;
                end
                if (m_axis_tdata[39:15] !== want.x_field)
                begin
                    $error("x_field: expected %0d, got %0d", want.x_field,
                           $signed(m_axis_tdata[39:15]));
                    mismatch_count++;
                end
                if (m_axis_tdata[64:40] !== want.y_field)
                begin
                    $error("y_field: expected %0d, got %0d", want.y_field,
                           $signed(m_axis_tdata[64:40]));
                    mismatch_count++;
                end
            end
        end
        if (rst_n && s_axis_tvalid && s_axis_tready)
            heading_q.push_back(predict_heading(s_axis_tdata[15:0], s_axis_tdata[31:16]));
    end

    task automatic add_sample(int xr, int yr);
        sample_q.push_back({16'(yr), 16'(xr)});
    endtask

    task automatic add_corners();
        add_sample(-32768, -32768);
        add_sample(32767, 32767);
        add_sample(32767, -32768);
        add_sample(-32768, 32767);
    endtask

    // mostly full-range counts, some close to the offsets for small vectors
    task automatic add_random_samples(int n);
        int xr;
        int yr;
        repeat (n)
        begin
            if ($urandom_range(99) < 70)
            begin
                xr = int'($urandom_range(65535));
                yr = int'($urandom_range(65535));
            end
            else
            begin
                xr = int'(x_off_cfg) + int'($urandom_range(64)) - 32;
                yr = int'(y_off_cfg) + int'($urandom_range(64)) - 32;
            end
            add_sample(xr, yr);
        end
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            mh_pkg::REG_X_BIAS: x_off_cfg = val[mh_pkg::OFF_W-1:0];
            mh_pkg::REG_Y_BIAS: y_off_cfg = val[mh_pkg::OFF_W-1:0];
            mh_pkg::REG_SCALE:  scale_cfg = val;
            default:            ;
        endcase
    endtask

    // upper bits of the offset writes are junk and must be dropped
    task automatic load_config(logic [mh_pkg::OFF_W-1:0] xo, logic [mh_pkg::OFF_W-1:0] yo,
                               logic [mh_pkg::SCALE_W-1:0] sc);
        write_reg(mh_pkg::REG_X_BIAS, {4'($urandom), xo});
        write_reg(REG_SPARE, 16'($urandom));
        write_reg(mh_pkg::REG_Y_BIAS, {4'($urandom), yo});
        write_reg(mh_pkg::REG_SCALE, sc);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (sample_q.size() != 0 || s_axis_tvalid || heading_q.size() != 0);
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // reset settings, directed samples
        add_corners();
        add_sample(11, -107);      // fields both zero
        add_sample(11, 1000);      // +y axis
        add_sample(11, -1000);     // -y axis
        add_sample(1000, -107);    // +x axis
        add_sample(-1000, -107);   // -x axis, y exactly zero
        add_sample(27, -91);       // rounding ties, both signs
        add_sample(-5, -123);
        add_sample(32767, -108);   // just below 360, rounds up and wraps
        add_sample(-32768, -106);
        add_sample(1011, 893);
        add_sample(12, -106);
        add_sample(10, -108);
        add_sample(-32768, -107);
        wait_drained();

        // random settings, full rate, long output hold-off
        load_config(12'($urandom), 12'($urandom), 16'($urandom));
        add_corners();
        add_random_samples(300);
        @(posedge clk);
        stall_kick <= 1'b1;
        @(posedge clk);
        stall_kick <= 1'b0;
        wait_drained();

        load_config(12'h800, 12'h7ff, 16'hffff);
        send_idle_pct = 79;
        add_corners();
        add_random_samples(250);
        wait_drained();

        load_config(12'h7ff, 12'h800, 16'h0000);
        send_idle_pct = 0;
        recv_stall_pct = 79;
        add_corners();
        add_random_samples(30);
        wait_drained();

        load_config(12'($urandom), 12'($urandom), 16'($urandom));
        add_random_samples(300);
        wait_drained();

        load_config(12'h000, 12'h000, 16'h1000);
        send_idle_pct = 9;
        recv_stall_pct = 9;
        add_corners();
        add_random_samples(300);
        wait_drained();

        repeat (PIPE_LATENCY + 8) @(posedge clk);
        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("Some tests failed");
        $finish;
    end

endmodule
